/* rtl/qsr_pkg.sv */
package qsr_pkg;

    localparam int SIG_W  = 114;
    localparam int ROOT_W = 114;
    localparam int REM_W  = 117;
    localparam int EXP_W  = 16;
    localparam int LZ_W   = 7;

    localparam logic [14:0] EXP_ALL_ONES = 15'h7FFF;
    localparam int          EXP_BIAS     = 16383;

    localparam logic [63:0] QUIET_HI       = 64'h0000_8000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN_HI = 64'h7FFF_8000_0000_0000;

    typedef struct packed {
        logic                    special;
        logic [127:0]            spec_val;
        logic signed [EXP_W-1:0] ex;
    } side_t;

endpackage

/* rtl/quad_precision_square_root.sv */
// Channel  Direction  Handshake            Payload
// in       to block   in_valid, in_stall   x_high, x_low
// out      from block out_valid, out_stall root_high, root_low
//
// One item enters per cycle unless in_stall is raised; the pipeline has 3 normalize stages,
// 114 root stages (one restoring digit each), 1 round and pack stage.
// Reset clears only the valid bits of the pipeline.
// A stalled output with a waiting result freezes the whole pipeline and
// raises in_stall in the same cycle; bubbles are not squeezed out.
module quad_precision_square_root (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] x_high,
    input  logic [63:0] x_low,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] root_high,
    output logic [63:0] root_low
);
    import qsr_pkg::*;

    logic en;

    logic             v_a    [0:ROOT_W];
    side_t            side_a [0:ROOT_W];
    logic [REM_W-1:0] r_a    [0:ROOT_W];
    logic [ROOT_W-1:0] q_a   [0:ROOT_W];
    logic [SIG_W-1:0] m_a    [0:ROOT_W];

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    qsr_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .x_high   (x_high),
        .x_low    (x_low),
        .valid    (v_a[0]),
        .side     (side_a[0]),
        .m        (m_a[0])
    );

    assign r_a[0] = '0;
    assign q_a[0] = '0;

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_step
        qsr_root_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (v_a[g]),
            .side_in   (side_a[g]),
            .r_in      (r_a[g]),
            .q_in      (q_a[g]),
            .m_in      (m_a[g]),
            .valid_out (v_a[g+1]),
            .side_out  (side_a[g+1]),
            .r_out     (r_a[g+1]),
            .q_out     (q_a[g+1]),
            .m_out     (m_a[g+1])
        );
    end

    qsr_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (v_a[ROOT_W]),
        .side_in   (side_a[ROOT_W]),
        .q_in      (q_a[ROOT_W]),
        .valid_out (out_valid),
        .root_high (root_high),
        .root_low  (root_low)
    );

endmodule

/* rtl/qsr_prep.sv */
module qsr_prep (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [63:0]                x_high,
    input  logic [63:0]                x_low,
    output logic                       valid,
    output qsr_pkg::side_t             side,
    output logic [qsr_pkg::SIG_W-1:0]  m
);
    import qsr_pkg::*;

    logic [14:0]   e;
    logic          frac_zero;
    side_t         s1_side_next;
    logic [112:0]  s1_m_next;

    side_t         s1_side_reg;
    logic [112:0]  s1_m_reg;
    logic          s1_valid_reg;

    logic [LZ_W-1:0] lz_next;
    side_t           s2_side_reg;
    logic [112:0]    s2_m_reg;
    logic [LZ_W-1:0] s2_lz_reg;
    logic            s2_valid_reg;

    logic [SIG_W-1:0]        sh_m;
    logic signed [EXP_W-1:0] sh_ex;
    side_t                   s3_side_next;
    logic [SIG_W-1:0]        s3_m_next;

    side_t            s3_side_reg;
    logic [SIG_W-1:0] s3_m_reg;
    logic             s3_valid_reg;

    // classify and unpack
    always_comb
    begin
        e         = x_high[62:48];
        frac_zero = (x_high[47:0] == 48'd0) && (x_low == 64'd0);
        s1_side_next.special  = 1'b1;
        s1_side_next.spec_val = {x_high, x_low};
        if (e == EXP_ALL_ONES && !frac_zero)
        begin
            s1_side_next.spec_val = {x_high | QUIET_HI, x_low};
        end
        else if (e == 15'd0 && frac_zero)
        begin
            s1_side_next.spec_val = {x_high, x_low};
        end
        else if (x_high[63])
        begin
            s1_side_next.spec_val = {DEFAULT_NAN_HI, 64'd0};
        end
        else if (e == EXP_ALL_ONES)
        begin
            s1_side_next.spec_val = {x_high, x_low};
        end
        else
        begin
            s1_side_next.special = 1'b0;
        end
        if (e != 15'd0)
            s1_side_next.ex = EXP_W'({1'b0, e}) - EXP_W'(EXP_BIAS);
        else
            s1_side_next.ex = EXP_W'(1 - EXP_BIAS);
        s1_m_next = {(e != 15'd0), x_high[47:0], x_low};
    end

    // leading zero count of the significand
    always_comb
    begin
        lz_next = '0;
        for (int k = 0; k < 113; k++)
        begin
            if (s1_m_reg[k])
                lz_next = LZ_W'(112 - k);
        end
    end

    // normalize, then make the exponent even
    always_comb
    begin
        sh_m  = {1'b0, s2_m_reg} << s2_lz_reg;
        sh_ex = s2_side_reg.ex - EXP_W'({1'b0, s2_lz_reg});
        s3_side_next = s2_side_reg;
        if (sh_ex[0])
        begin
            s3_m_next       = {sh_m[SIG_W-2:0], 1'b0};
            s3_side_next.ex = sh_ex - EXP_W'(1);
        end
        else
        begin
            s3_m_next       = sh_m;
            s3_side_next.ex = sh_ex;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= s1_side_next;
            s1_m_reg    <= s1_m_next;
            s2_side_reg <= s1_side_reg;
            s2_m_reg    <= s1_m_reg;
            s2_lz_reg   <= lz_next;
            s3_side_reg <= s3_side_next;
            s3_m_reg    <= s3_m_next;
        end
    end

    assign valid = s3_valid_reg;
    assign side  = s3_side_reg;
    assign m     = s3_m_reg;

endmodule

/* rtl/qsr_root_step.sv */
module qsr_root_step (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid_in,
    input  qsr_pkg::side_t              side_in,
    input  logic [qsr_pkg::REM_W-1:0]   r_in,
    input  logic [qsr_pkg::ROOT_W-1:0]  q_in,
    input  logic [qsr_pkg::SIG_W-1:0]   m_in,
    output logic                        valid_out,
    output qsr_pkg::side_t              side_out,
    output logic [qsr_pkg::REM_W-1:0]   r_out,
    output logic [qsr_pkg::ROOT_W-1:0]  q_out,
    output logic [qsr_pkg::SIG_W-1:0]   m_out
);
    import qsr_pkg::*;

    logic [REM_W-1:0]  r_sh;
    logic [REM_W-1:0]  t;
    logic [REM_W-1:0]  r_next;
    logic [ROOT_W-1:0] q_next;
    logic              valid_reg;
    side_t             side_reg;
    logic [REM_W-1:0]  r_reg;
    logic [ROOT_W-1:0] q_reg;
    logic [SIG_W-1:0]  m_reg;

    // one restoring step: bring down two radicand bits, try (4q+1)
    always_comb
    begin
        r_sh   = {r_in[REM_W-3:0], m_in[SIG_W-1:SIG_W-2]};
        t      = REM_W'({q_in, 2'b01});
        q_next = {q_in[ROOT_W-2:0], 1'b0};
        r_next = r_sh;
        if (r_sh >= t)
        begin
            r_next    = r_sh - t;
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            r_reg    <= r_next;
            q_reg    <= q_next;
            m_reg    <= {m_in[SIG_W-3:0], 2'b00};
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign r_out     = r_reg;
    assign q_out     = q_reg;
    assign m_out     = m_reg;

endmodule

/* rtl/qsr_round.sv */
module qsr_round (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid_in,
    input  qsr_pkg::side_t              side_in,
    input  logic [qsr_pkg::ROOT_W-1:0]  q_in,
    output logic                        valid_out,
    output logic [63:0]                 root_high,
    output logic [63:0]                 root_low
);
    import qsr_pkg::*;

    logic [112:0]            s;
    logic signed [EXP_W-1:0] biased;
    logic [127:0]            res_next;
    logic                    valid_reg;
    logic [127:0]            res_reg;

    // drop the guard bit and round; a tie cannot occur
    always_comb
    begin
        s      = q_in[ROOT_W-1:1] + 113'(q_in[0]);
        biased = (side_in.ex >>> 1) + EXP_W'(EXP_BIAS - 1);
        // hidden bit of the root carries one into the exponent field
        res_next[127:64] = (64'(unsigned'(biased)) << 48) + 64'(s[112:64]);
        res_next[63:0]   = s[63:0];
        if (side_in.special)
            res_next = side_in.spec_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign valid_out = valid_reg;
    assign root_high = res_reg[127:64];
    assign root_low  = res_reg[63:0];

endmodule

/* verif/quad_precision_square_root_tb.sv */
module quad_precision_square_root_tb;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] x_high;
    logic [63:0] x_low;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] root_high;
    logic [63:0] root_low;

    int send_idle_pct;
    int recv_stall_pct;
    bit failed;

    quad_precision_square_root dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .x_high(x_high), .x_low(x_low),
        .out_valid(out_valid), .out_stall(out_stall),
        .root_high(root_high), .root_low(root_low)
    );

    class root_scoreboard;
        logic [127:0] pending_roots[$];
        int mismatches;

        function logic [127:0] sqrt128(logic [63:0] xh, logic [63:0] xl);
            logic [14:0]  e;
            logic [112:0] m;
            logic [227:0] rad;
            logic [117:0] rem;
            logic [117:0] trial;
            logic [113:0] q;
            logic [112:0] s;
            int           ex;
            logic [63:0]  biased;
            e = xh[62:48];
            if (e == qsr_pkg::EXP_ALL_ONES && {xh[47:0], xl} != 0)
                return {xh | qsr_pkg::QUIET_HI, xl};
            if (e == 0 && {xh[47:0], xl} == 0)
                return {xh, xl};
            if (xh[63])
                return {qsr_pkg::DEFAULT_NAN_HI, 64'd0};
            if (e == qsr_pkg::EXP_ALL_ONES)
                return {xh, xl};
            m = {1'b0, xh[47:0], xl};
            if (e != 0) begin
                m[112] = 1'b1;
                ex = int'(e) - qsr_pkg::EXP_BIAS;
            end
            else begin
                ex = 1 - qsr_pkg::EXP_BIAS;
                while (!m[112]) begin
                    m = m << 1;
                    ex--;
                end
            end
            rad = {115'd0, m} << 114;
            if (ex % 2 != 0) begin
                rad = rad << 1;
                ex--;
            end
            rem = 0;
            q = 0;
            for (int i = 113; i >= 0; i--) begin
                rem = (rem << 2) | 118'(rad[2*i +: 2]);
                trial = 118'({q, 2'b01});
                q = q << 1;
                if (rem >= trial) begin
                    rem = rem - trial;
                    q[0] = 1'b1;
                end
            end
            s = q[113:1] + 113'(q[0]);
            biased = 64'(ex / 2 + qsr_pkg::EXP_BIAS - 1);
            return {(biased << 48) + {15'd0, s[112:64]}, s[63:0]};
        endfunction

        function void note_operand(logic [63:0] xh, logic [63:0] xl);
            pending_roots.push_back(sqrt128(xh, xl));
        endfunction

        function void check_root(logic [63:0] rh, logic [63:0] rl);
            logic [127:0] want;
            if (pending_roots.size() == 0) begin
                $error("unexpected root %h_%h", rh, rl);
                mismatches++;
                return;
            end
            want = pending_roots.pop_front();
            if (rh !== want[127:64]) begin
                $error("root_high expected %h actual %h", want[127:64], rh);
                mismatches++;
            end
            if (rl !== want[63:0]) begin
                $error("root_low expected %h actual %h", want[63:0], rl);
                mismatches++;
            end
        endfunction
    endclass

    root_scoreboard sb;

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver: stall at random, check accepted roots
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_root(root_high, root_low);
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_operand(logic [63:0] xh, logic [63:0] xl);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        x_high <= xh;
        x_low <= xl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_operand(xh, xl);
    endtask

    task automatic send_random();
        logic [63:0] xh;
        logic [63:0] xl;
        int kind;
        xh = rand64();
        xl = rand64();
        kind = $urandom_range(19);
        if (kind == 0)
            xh[62:48] = qsr_pkg::EXP_ALL_ONES;
        else if (kind == 1)
            xh[62:48] = 0;
        else if (kind == 2) begin
            xh[62:48] = 0;
            xh[47:0] = 0;
            xl = xl >> $urandom_range(63);
        end
        else if (kind == 3) begin
            xh[62:0] = 0;
            xl = 0;
        end
        else if (kind == 4) begin
            xh[47:0] = 0;
            xl = 0;
        end
        if (kind >= 5 && kind < 15)
            xh[63] = 1'b0;
        send_operand(xh, xl);
    endtask

    task automatic drain();
        int n;
        in_valid <= 1'b0;
        n = 0;
        while (sb.pending_roots.size() != 0 && n < 400000) begin
            @(posedge clk);
            n++;
        end
        repeat (130) @(posedge clk);
    endtask

    initial begin
        sb = new();
        rst_n = 0;
        in_valid = 0;
        x_high = 0;
        x_low = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_operand(64'h0000_0000_0000_0000, 64'h0);
        send_operand(64'h8000_0000_0000_0000, 64'h0);
        send_operand(64'h7FFF_0000_0000_0000, 64'h0);
        send_operand(64'hFFFF_0000_0000_0000, 64'h0);
        send_operand(64'h7FFF_0000_0000_0000, 64'h1);
        send_operand(64'hFFFF_4000_0000_0000, 64'hDEAD_BEEF);
        send_operand(64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_operand(64'h8000_0000_0000_0000, 64'h1);
        send_operand(64'hBFFF_0000_0000_0000, 64'h0);
        send_operand(64'h0000_0000_0000_0000, 64'h1);
        send_operand(64'h0000_8000_0000_0000, 64'h0);
        send_operand(64'h0000_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_operand(64'h0001_0000_0000_0000, 64'h0);
        send_operand(64'h3FFF_0000_0000_0000, 64'h0);
        send_operand(64'h4000_0000_0000_0000, 64'h0);
        send_operand(64'h4001_0000_0000_0000, 64'h0);
        send_operand(64'h7FFE_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_operand(64'h3FFE_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_operand(64'h3FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 88 : 29) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 88 : 29) : 0;
            for (int k = 0; k < 500; k++)
                send_random();
            drain();
        end

        if (sb.mismatches == 0 && sb.pending_roots.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
rtl/qsr_pkg.sv
rtl/qsr_prep.sv
rtl/qsr_root_step.sv
rtl/qsr_round.sv
rtl/quad_precision_square_root.sv
verif/quad_precision_square_root_tb.sv
